[rtl/core/tiba_pkg.sv]
// Package for the tagged integer / truth-value ALU.
// Holds widths, opcodes, status codes, type tags and sequencer states.
// No dependencies; every other file of the block uses it.
`default_nettype none

package tiba_pkg;

  localparam int DataWidth = 32;
  localparam int CmdW      = 4;
  localparam int StatW     = 2;
  localparam int CntW      = $clog2(DataWidth);

  typedef logic [DataWidth-1:0] word_t;
  typedef logic [CntW-1:0]      cnt_t;

  typedef enum logic [CmdW-1:0] {
    CMD_NOT = 4'd0,
    CMD_NEG = 4'd1,
    CMD_AND = 4'd2,
    CMD_OR  = 4'd3,
    CMD_EQ  = 4'd4,
    CMD_NE  = 4'd5,
    CMD_ADD = 4'd6,
    CMD_SUB = 4'd7,
    CMD_MUL = 4'd8,
    CMD_POW = 4'd9,
    CMD_DIV = 4'd10,
    CMD_GR  = 4'd11,
    CMD_GE  = 4'd12,
    CMD_LS  = 4'd13,
    CMD_LE  = 4'd14
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK   = 2'd0,
    STAT_TYPE = 2'd1,
    STAT_ZERO = 2'd2
  } status_e;

  localparam logic KIND_INT  = 1'b0;
  localparam logic KIND_BOOL = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POW,
    S_DIV,
    S_FIX,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

[rtl/core/tiba_if.sv]
// Valid/ready channels of the tagged ALU: operation items in, result items out.
// Depends on tiba_pkg for field widths.
`default_nettype none

interface tiba_op_if;
  logic                                valid;
  logic                                ready;
  logic [tiba_pkg::CmdW-1:0]           command;
  logic signed [tiba_pkg::DataWidth-1:0] operand_a;
  logic                                operand_a_kind;
  logic signed [tiba_pkg::DataWidth-1:0] operand_b;
  logic                                operand_b_kind;

  modport source (
    output valid, command, operand_a, operand_a_kind, operand_b, operand_b_kind,
    input  ready
  );
  modport sink (
    input  valid, command, operand_a, operand_a_kind, operand_b, operand_b_kind,
    output ready
  );
endinterface

interface tiba_res_if;
  logic                                valid;
  logic                                ready;
  logic signed [tiba_pkg::DataWidth-1:0] result_value;
  logic                                result_kind;
  logic [tiba_pkg::StatW-1:0]          status;

  modport source (
    output valid, result_value, result_kind, status,
    input  ready
  );
  modport sink (
    input  valid, result_value, result_kind, status,
    output ready
  );
endinterface

`default_nettype wire

[rtl/core/tagged_integer_boolean_alu.sv]
// Tagged integer / truth-value ALU with iterative power and divide.
// Channels: cmd_i takes one operation item (opcode, two tagged operands);
// res_o returns one tagged result item with a status for each.
// An item is taken on a cycle where valid and ready are both high.
// cmd_i.ready is high only while the sequencer is idle; one item at a time.
// Steps from acceptance to the result being offered on res_o:
//   logic, compare, add, sub, neg, mul, errors: a decode step, then a result load
//   div: decode, one restoring step per quotient bit, a sign fix, result load;
//   a zero divisor or a negative exponent goes straight from decode to the load
//   pow, non-negative exponent: decode, then an accumulate and a square step
//   per exponent bit until the exponent is zero; the one shared 32x32 multiplier
//   does one multiply a cycle, alternating accumulate and square.
// The next item can be taken once the sequencer is back in idle.
// The result sits in an output register; a new item is accepted while it
// waits. If the receiver stalls and the next result is ready, the sequencer
// holds it until the output register frees up.
// Reset (rst_ni low, asynchronous) empties the output register and returns
// the sequencer to idle; no other state is kept between items.
// Depends on tiba_pkg and the channel interfaces in tiba_if.sv.
`default_nettype none

module tagged_integer_boolean_alu (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tiba_op_if.sink    cmd_i,
  tiba_res_if.source res_o
);

  tiba_pkg::state_e  state_q, state_d;
  tiba_pkg::cmd_e    cmd_q, cmd_d;
  tiba_pkg::word_t   a_q, a_d;      // operand a; square in pow, dividend/quotient in div
  tiba_pkg::word_t   b_q, b_d;      // operand b; exponent in pow, divisor in div
  logic              ka_q, ka_d, kb_q, kb_d;
  tiba_pkg::word_t   rem_q, rem_d;
  tiba_pkg::cnt_t    cnt_q, cnt_d;
  logic              phase_q, phase_d;
  logic              neg_q, neg_d;
  tiba_pkg::word_t   rv_q, rv_d;    // result value; accumulator in pow
  logic              rk_q, rk_d;
  tiba_pkg::status_e rs_q, rs_d;

  logic              ov_q, ov_d;
  tiba_pkg::word_t   out_val_q, out_val_d;
  logic              out_kind_q, out_kind_d;
  tiba_pkg::status_e out_stat_q, out_stat_d;

  // Shared multiplier: operands chosen by the sequencer, low word kept.
  tiba_pkg::word_t                     mul_x, mul_y, mul_lo;

  // Adder / compare unit on operands.
  logic [tiba_pkg::DataWidth:0]        sub_ext;
  tiba_pkg::word_t                     sum_ab;
  logic                                lt_ab, eq_ab, ints, truths, ta, tb;

  // Restoring divide step.
  logic [tiba_pkg::DataWidth:0]        shifted;
  logic [tiba_pkg::DataWidth+1:0]      trial;

  logic out_free;

  assign mul_x  = (state_q == tiba_pkg::S_POW && !phase_q) ? rv_q : a_q;
  assign mul_y  = (state_q == tiba_pkg::S_POW) ? a_q : b_q;
  assign mul_lo = mul_x * mul_y;

  assign sub_ext = {a_q[tiba_pkg::DataWidth-1], a_q} - {b_q[tiba_pkg::DataWidth-1], b_q};
  assign sum_ab  = a_q + b_q;
  assign lt_ab   = sub_ext[tiba_pkg::DataWidth];
  assign eq_ab   = (a_q == b_q);
  assign ints    = (ka_q == tiba_pkg::KIND_INT) && (kb_q == tiba_pkg::KIND_INT);
  assign truths  = (ka_q == tiba_pkg::KIND_BOOL) && (kb_q == tiba_pkg::KIND_BOOL);
  assign ta      = (a_q != '0);
  assign tb      = (b_q != '0);

  assign shifted = {rem_q, a_q[tiba_pkg::DataWidth-1]};
  assign trial   = {1'b0, shifted} - {2'b00, b_q};

  assign out_free = !ov_q || res_o.ready;

  assign cmd_i.ready        = (state_q == tiba_pkg::S_IDLE);
  assign res_o.valid        = ov_q;
  assign res_o.result_value = out_val_q;
  assign res_o.result_kind  = out_kind_q;
  assign res_o.status       = out_stat_q;

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    a_d        = a_q;
    b_d        = b_q;
    ka_d       = ka_q;
    kb_d       = kb_q;
    rem_d      = rem_q;
    cnt_d      = cnt_q;
    phase_d    = phase_q;
    neg_d      = neg_q;
    rv_d       = rv_q;
    rk_d       = rk_q;
    rs_d       = rs_q;
    ov_d       = ov_q;
    out_val_d  = out_val_q;
    out_kind_d = out_kind_q;
    out_stat_d = out_stat_q;

    if (ov_q && res_o.ready) begin
      ov_d = 1'b0;
    end

    case (state_q)
      tiba_pkg::S_IDLE: begin
        if (cmd_i.valid) begin
          cmd_d   = tiba_pkg::cmd_e'(cmd_i.command);
          a_d     = cmd_i.operand_a;
          b_d     = cmd_i.operand_b;
          ka_d    = cmd_i.operand_a_kind;
          kb_d    = cmd_i.operand_b_kind;
          state_d = tiba_pkg::S_EXEC;
        end
      end

      tiba_pkg::S_EXEC: begin
        rv_d    = '0;
        rk_d    = tiba_pkg::KIND_INT;
        rs_d    = tiba_pkg::STAT_OK;
        state_d = tiba_pkg::S_DONE;
        case (cmd_q)
          tiba_pkg::CMD_NOT: begin
            if (ka_q == tiba_pkg::KIND_BOOL) begin
              rv_d = tiba_pkg::word_t'(!ta);
              rk_d = tiba_pkg::KIND_BOOL;
            end else begin
              rs_d = tiba_pkg::STAT_TYPE;
            end
          end
          tiba_pkg::CMD_NEG: begin
            if (ka_q == tiba_pkg::KIND_INT) begin
              rv_d = '0 - a_q;
            end else begin
              rs_d = tiba_pkg::STAT_TYPE;
            end
          end
          tiba_pkg::CMD_AND, tiba_pkg::CMD_OR: begin
            if (truths) begin
              rv_d = (cmd_q == tiba_pkg::CMD_AND) ? tiba_pkg::word_t'(ta && tb)
                                                  : tiba_pkg::word_t'(ta || tb);
              rk_d = tiba_pkg::KIND_BOOL;
            end else begin
              rs_d = tiba_pkg::STAT_TYPE;
            end
          end
          tiba_pkg::CMD_EQ, tiba_pkg::CMD_NE: begin
            if (ka_q != kb_q) begin
              rs_d = tiba_pkg::STAT_TYPE;
            end else begin
              // truth operands compare by truth, not by raw bits
              rv_d = tiba_pkg::word_t'(((ka_q == tiba_pkg::KIND_BOOL) ? (ta == tb) : eq_ab)
                                       == (cmd_q == tiba_pkg::CMD_EQ));
              rk_d = tiba_pkg::KIND_BOOL;
            end
          end
          tiba_pkg::CMD_ADD, tiba_pkg::CMD_SUB, tiba_pkg::CMD_MUL, tiba_pkg::CMD_POW,
          tiba_pkg::CMD_DIV, tiba_pkg::CMD_GR, tiba_pkg::CMD_GE, tiba_pkg::CMD_LS,
          tiba_pkg::CMD_LE: begin
            if (!ints) begin
              rs_d = tiba_pkg::STAT_TYPE;
            end else begin
              case (cmd_q)
                tiba_pkg::CMD_ADD: rv_d = sum_ab;
                tiba_pkg::CMD_SUB: rv_d = sub_ext[tiba_pkg::DataWidth-1:0];
                tiba_pkg::CMD_MUL: rv_d = mul_lo;
                tiba_pkg::CMD_POW: begin
                  if (!b_q[tiba_pkg::DataWidth-1]) begin
                    rv_d    = tiba_pkg::word_t'(1);
                    phase_d = 1'b0;
                    state_d = tiba_pkg::S_POW;
                  end else if (a_q == tiba_pkg::word_t'(1)) begin
                    rv_d = tiba_pkg::word_t'(1);
                  end else if (a_q == '1) begin
                    // base -1: sign follows exponent parity
                    rv_d = b_q[0] ? '1 : tiba_pkg::word_t'(1);
                  end else if (a_q == '0) begin
                    rs_d = tiba_pkg::STAT_ZERO;
                  end
                end
                tiba_pkg::CMD_DIV: begin
                  if (b_q == '0) begin
                    rs_d = tiba_pkg::STAT_ZERO;
                  end else begin
                    a_d     = a_q[tiba_pkg::DataWidth-1] ? '0 - a_q : a_q;
                    b_d     = b_q[tiba_pkg::DataWidth-1] ? '0 - b_q : b_q;
                    neg_d   = a_q[tiba_pkg::DataWidth-1] ^ b_q[tiba_pkg::DataWidth-1];
                    rem_d   = '0;
                    cnt_d   = '0;
                    state_d = tiba_pkg::S_DIV;
                  end
                end
                tiba_pkg::CMD_GR: begin
                  rv_d = tiba_pkg::word_t'(!lt_ab && !eq_ab);
                  rk_d = tiba_pkg::KIND_BOOL;
                end
                tiba_pkg::CMD_GE: begin
                  rv_d = tiba_pkg::word_t'(!lt_ab);
                  rk_d = tiba_pkg::KIND_BOOL;
                end
                tiba_pkg::CMD_LS: begin
                  rv_d = tiba_pkg::word_t'(lt_ab);
                  rk_d = tiba_pkg::KIND_BOOL;
                end
                default: begin
                  rv_d = tiba_pkg::word_t'(lt_ab || eq_ab);
                  rk_d = tiba_pkg::KIND_BOOL;
                end
              endcase
            end
          end
          default: begin
            rs_d = tiba_pkg::STAT_TYPE;
          end
        endcase
      end

      // square and multiply, LSB first: phase 0 accumulates, phase 1 squares
      tiba_pkg::S_POW: begin
        if (!phase_q) begin
          if (b_q == '0) begin
            state_d = tiba_pkg::S_DONE;
          end else begin
            if (b_q[0]) begin
              rv_d = mul_lo;
            end
            phase_d = 1'b1;
          end
        end else begin
          a_d     = mul_lo;
          b_d     = b_q >> 1;
          phase_d = 1'b0;
        end
      end

      tiba_pkg::S_DIV: begin
        if (!trial[tiba_pkg::DataWidth+1]) begin
          rem_d = trial[tiba_pkg::DataWidth-1:0];
          a_d   = {a_q[tiba_pkg::DataWidth-2:0], 1'b1};
        end else begin
          rem_d = shifted[tiba_pkg::DataWidth-1:0];
          a_d   = {a_q[tiba_pkg::DataWidth-2:0], 1'b0};
        end
        cnt_d = cnt_q + tiba_pkg::cnt_t'(1);
        if (cnt_q == tiba_pkg::cnt_t'(tiba_pkg::DataWidth - 1)) begin
          state_d = tiba_pkg::S_FIX;
        end
      end

      tiba_pkg::S_FIX: begin
        rv_d    = neg_q ? '0 - a_q : a_q;
        state_d = tiba_pkg::S_DONE;
      end

      tiba_pkg::S_DONE: begin
        if (out_free) begin
          ov_d       = 1'b1;
          out_val_d  = rv_q;
          out_kind_d = rk_q;
          out_stat_d = rs_q;
          state_d    = tiba_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = tiba_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tiba_pkg::S_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    a_q        <= a_d;
    b_q        <= b_d;
    ka_q       <= ka_d;
    kb_q       <= kb_d;
    rem_q      <= rem_d;
    cnt_q      <= cnt_d;
    phase_q    <= phase_d;
    neg_q      <= neg_d;
    rv_q       <= rv_d;
    rk_q       <= rk_d;
    rs_q       <= rs_d;
    out_val_q  <= out_val_d;
    out_kind_q <= out_kind_d;
    out_stat_q <= out_stat_d;
  end

  // accepted item always goes to decode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.valid && cmd_i.ready) |=> (state_q == tiba_pkg::S_EXEC))
    else $error("accepted item did not enter decode");

  // an error result carries zero value and integer kind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.status != tiba_pkg::STAT_OK) |->
      (res_o.result_value == '0 && res_o.result_kind == tiba_pkg::KIND_INT))
    else $error("error item with nonzero payload");

  // truth results are 0 or 1
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.result_kind == tiba_pkg::KIND_BOOL) |->
      (res_o.result_value[tiba_pkg::DataWidth-1:1] == '0))
    else $error("truth result out of range");

  // divide always starts from step zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tiba_pkg::S_DIV && $past(state_q) == tiba_pkg::S_EXEC) |->
      (cnt_q == '0 && rem_q == '0))
    else $error("divide entered with stale step count");

  // squaring phase never ends the power loop
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tiba_pkg::S_POW && phase_q) |=> (state_q == tiba_pkg::S_POW && !phase_q))
    else $error("power loop left from squaring phase");

endmodule

`default_nettype wire

[bench/tb_tagged_integer_boolean_alu.sv]
// Testbench for the tagged integer / truth-value ALU: directed corner items, then random ones.
// Results are checked against an in-bench predictor. Uses tiba_pkg and the tiba_if.sv channels.
`timescale 1ns / 100ps

module tb_tagged_integer_boolean_alu;
  import tiba_pkg::*;

  // opcode 15 has no operation behind it
  localparam logic [CmdW-1:0] CMD_RESERVED = 4'd15;
  localparam int RandomItems   = 1000;
  localparam int TailCycles    = 80;
  localparam int MaxPrinted    = 100;

  typedef struct packed {
    logic [CmdW-1:0] command;
    word_t           a;
    logic            a_kind;
    word_t           b;
    logic            b_kind;
    logic            drain;  // hold this item until all results are back
    logic [7:0]      gap;    // idle cycles before the item is offered
  } alu_op_t;

  typedef struct packed {
    word_t   value;
    logic    kind;
    status_e status;
  } alu_result_t;

  logic clk_i;
  logic rst_ni;

  tiba_op_if  op_ch ();
  tiba_res_if res_ch ();

  tagged_integer_boolean_alu dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (op_ch),
    .res_o  (res_ch)
  );

  alu_op_t     pending_ops[$];
  alu_result_t expected_results[$];
  alu_op_t     cur_op;
  alu_result_t want;
  int          idle_cycles;
  int          stall_left;
  int          cycle_cnt;
  int          error_count = 0;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  function automatic alu_result_t alu_predict(alu_op_t op);
    alu_result_t r;
    word_t       acc;
    word_t       sq;
    word_t       ex;
    word_t       ma;
    word_t       mb;
    word_t       q;
    logic        ta;
    logic        tb;
    logic        ints;
    r.value  = '0;
    r.kind   = KIND_INT;
    r.status = STAT_OK;
    ta   = |op.a;
    tb   = |op.b;
    ints = (op.a_kind == KIND_INT) && (op.b_kind == KIND_INT);
    case (op.command)
      CMD_NOT: begin
        if (op.a_kind == KIND_BOOL) begin
          r.value = word_t'(!ta);
          r.kind  = KIND_BOOL;
        end else r.status = STAT_TYPE;
      end
      CMD_NEG: begin
        if (op.a_kind == KIND_INT) r.value = -op.a;
        else r.status = STAT_TYPE;
      end
      CMD_AND, CMD_OR: begin
        if (op.a_kind == KIND_BOOL && op.b_kind == KIND_BOOL) begin
          r.value = (op.command == CMD_AND) ? word_t'(ta && tb) : word_t'(ta || tb);
          r.kind  = KIND_BOOL;
        end else r.status = STAT_TYPE;
      end
      CMD_EQ, CMD_NE: begin
        if (op.a_kind != op.b_kind) begin
          r.status = STAT_TYPE;
        end else begin
          // truth values compare by truth, not by raw bits
          r.value = word_t'((op.a_kind == KIND_BOOL) ? (ta == tb) : (op.a == op.b));
          if (op.command == CMD_NE) r.value = word_t'(!r.value[0]);
          r.kind = KIND_BOOL;
        end
      end
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_POW, CMD_DIV, CMD_GR, CMD_GE, CMD_LS, CMD_LE: begin
        if (!ints) begin
          r.status = STAT_TYPE;
        end else begin
          case (op.command)
            CMD_ADD: r.value = op.a + op.b;
            CMD_SUB: r.value = op.a - op.b;
            CMD_MUL: r.value = op.a * op.b;
            CMD_POW: begin
              if (!op.b[DataWidth-1]) begin
                acc = 1;
                sq  = op.a;
                ex  = op.b;
                for (int i = 0; i < DataWidth; i++) begin
                  if (ex[0]) acc = acc * sq;
                  sq = sq * sq;
                  ex = ex >> 1;
                end
                r.value = acc;
              end else if (op.a == word_t'(1)) begin
                r.value = 1;
              end else if (op.a == '1) begin
                r.value = op.b[0] ? '1 : word_t'(1);
              end else if (op.a == '0) begin
                r.status = STAT_ZERO;
              end else begin
                r.value = '0;
              end
            end
            CMD_DIV: begin
              if (op.b == '0) begin
                r.status = STAT_ZERO;
              end else begin
                ma = op.a[DataWidth-1] ? -op.a : op.a;
                mb = op.b[DataWidth-1] ? -op.b : op.b;
                q  = ma / mb;
                r.value = (op.a[DataWidth-1] != op.b[DataWidth-1]) ? -q : q;
              end
            end
            CMD_GR: r.value = word_t'($signed(op.a) >  $signed(op.b));
            CMD_GE: r.value = word_t'($signed(op.a) >= $signed(op.b));
            CMD_LS: r.value = word_t'($signed(op.a) <  $signed(op.b));
            default: r.value = word_t'($signed(op.a) <= $signed(op.b));
          endcase
          if (op.command >= CMD_GR) r.kind = KIND_BOOL;
        end
      end
      default: r.status = STAT_TYPE;
    endcase
    if (r.status != STAT_OK) begin
      r.value = '0;
      r.kind  = KIND_INT;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, word_t got, word_t exp_val);
    if (error_count < MaxPrinted)
      $display("%0t mismatch on %s: got %h, expected %h", $time, what, got, exp_val);
    error_count++;
  endtask

  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2: return word_t'(int'($urandom_range(0, 8)) - 4);
      3: begin
        case ($urandom_range(0, 4))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return '0;
          3: return 32'h0000_0001;
          default: return '1;
        endcase
      end
      4: return word_t'(1) << $urandom_range(0, DataWidth - 1);
      default: return $urandom_range(0, 1000);
    endcase
  endfunction

  function automatic word_t rand_truth();
    if ($urandom_range(0, 9) < 8) return word_t'($urandom_range(0, 1));
    return rand_word();
  endfunction

  function automatic alu_op_t make_random_op(int idx);
    alu_op_t o;
    o = '0;
    o.command = ($urandom_range(0, 39) == 0) ? CMD_RESERVED : 4'($urandom_range(0, 14));
    o.a_kind  = 1'($urandom_range(0, 1));
    o.b_kind  = 1'($urandom_range(0, 1));
    // most items carry the kinds their operation wants
    if ($urandom_range(0, 99) < 88) begin
      case (o.command)
        CMD_NOT: o.a_kind = KIND_BOOL;
        CMD_NEG: o.a_kind = KIND_INT;
        CMD_AND, CMD_OR: begin
          o.a_kind = KIND_BOOL;
          o.b_kind = KIND_BOOL;
        end
        CMD_EQ, CMD_NE: o.b_kind = o.a_kind;
        default: begin
          o.a_kind = KIND_INT;
          o.b_kind = KIND_INT;
        end
      endcase
    end
    o.a = (o.a_kind == KIND_BOOL) ? rand_truth() : rand_word();
    o.b = (o.b_kind == KIND_BOOL) ? rand_truth() : rand_word();
    if (o.command == CMD_POW && o.b_kind == KIND_INT) begin
      case ($urandom_range(0, 5))
        0, 1, 2: o.b = $urandom_range(0, 40);
        3: o.b = word_t'(-int'($urandom_range(1, 6)));
        default: ;
      endcase
    end
    o.gap   = 8'(pick_gap(((idx / 150) % 4) == 3));
    o.drain = (idx % 250) == 0;
    return o;
  endfunction

  task automatic push_op(logic [CmdW-1:0] cmd, word_t a, logic ka, word_t b, logic kb);
    alu_op_t o;
    o.command = cmd;
    o.a       = a;
    o.a_kind  = ka;
    o.b       = b;
    o.b_kind  = kb;
    o.drain   = 1'b0;
    o.gap     = 8'(pick_gap(1'b0));
    pending_ops = {pending_ops, o};
  endtask

  // Sender: offers the head of pending_ops, predicts on acceptance.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_ch.valid <= 1'b0;
      idle_cycles = 0;
    end else begin
      if (op_ch.valid && op_ch.ready)
        expected_results = {expected_results, alu_predict(cur_op)};
      if (!op_ch.valid || op_ch.ready) begin
        if (pending_ops.size() != 0 && idle_cycles >= int'(pending_ops[0].gap) &&
            !(pending_ops[0].drain && expected_results.size() != 0)) begin
          cur_op = pending_ops.pop_front();
          op_ch.valid          <= 1'b1;
          op_ch.command        <= cur_op.command;
          op_ch.operand_a      <= cur_op.a;
          op_ch.operand_a_kind <= cur_op.a_kind;
          op_ch.operand_b      <= cur_op.b;
          op_ch.operand_b_kind <= cur_op.b_kind;
          idle_cycles = 0;
        end else begin
          op_ch.valid <= 1'b0;
          idle_cycles++;
        end
      end
    end
  end

  // Receiver: random stalls, with stall-free windows; checks each result item.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
      stall_left = 0;
      cycle_cnt  = 0;
    end else begin
      cycle_cnt++;
      if (res_ch.valid && res_ch.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", res_ch.result_value, '0);
        end else begin
          want = expected_results.pop_front();
          if (res_ch.result_value !== want.value)
            report_mismatch("result_value", res_ch.result_value, want.value);
          if (res_ch.result_kind !== want.kind)
            report_mismatch("result_kind", word_t'(res_ch.result_kind), word_t'(want.kind));
          if (res_ch.status !== want.status)
            report_mismatch("status", word_t'(res_ch.status), word_t'(want.status));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else if (((cycle_cnt / 400) % 4) != 1 && $urandom_range(0, 99) < 20) begin
        stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                  : $urandom_range(9, 59);
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    op_ch.valid          = 1'b0;
    op_ch.command        = '0;
    op_ch.operand_a      = '0;
    op_ch.operand_a_kind = 1'b0;
    op_ch.operand_b      = '0;
    op_ch.operand_b_kind = 1'b0;
    res_ch.ready         = 1'b0;
    rst_ni               = 1'b0;

    // directed corners
    push_op(CMD_NOT, '0,           KIND_BOOL, 32'h1234_5678, KIND_INT);
    push_op(CMD_NOT, 32'h8000_0000, KIND_BOOL, '1,           KIND_BOOL);
    push_op(CMD_NOT, 32'h0000_0001, KIND_INT,  '0,           KIND_BOOL);
    push_op(CMD_NEG, 32'h8000_0000, KIND_INT,  32'h0000_0001, KIND_BOOL);
    push_op(CMD_NEG, 32'h0000_0005, KIND_BOOL, '0,           KIND_INT);
    push_op(CMD_AND, 32'h0000_0005, KIND_BOOL, 32'h0000_0001, KIND_BOOL);
    push_op(CMD_OR,  '0,           KIND_BOOL, '0,           KIND_BOOL);
    push_op(CMD_AND, 32'h0000_0001, KIND_INT,  32'h0000_0001, KIND_BOOL);
    push_op(CMD_EQ,  32'h0000_0003, KIND_BOOL, 32'h0000_0001, KIND_BOOL);
    push_op(CMD_NE,  32'h7FFF_FFFF, KIND_INT,  32'h8000_0000, KIND_INT);
    push_op(CMD_EQ,  32'h0000_0001, KIND_INT,  32'h0000_0001, KIND_BOOL);
    push_op(CMD_ADD, 32'h7FFF_FFFF, KIND_INT,  32'h0000_0001, KIND_INT);
    push_op(CMD_SUB, 32'h8000_0000, KIND_INT,  32'h0000_0001, KIND_INT);
    push_op(CMD_MUL, '1,           KIND_INT,  32'h8000_0000, KIND_INT);
    push_op(CMD_POW, 32'h0000_0003, KIND_INT,  32'h7FFF_FFFF, KIND_INT);
    push_op(CMD_POW, '0,           KIND_INT,  '0,           KIND_INT);
    push_op(CMD_POW, 32'h0000_0001, KIND_INT,  32'hFFFF_FFFB, KIND_INT);
    push_op(CMD_POW, '1,           KIND_INT,  32'hFFFF_FFFC, KIND_INT);
    push_op(CMD_POW, '1,           KIND_INT,  32'hFFFF_FFFD, KIND_INT);
    push_op(CMD_POW, '0,           KIND_INT,  '1,           KIND_INT);
    push_op(CMD_POW, 32'h0000_0007, KIND_INT,  32'h8000_0000, KIND_INT);
    push_op(CMD_DIV, 32'h8000_0000, KIND_INT,  '1,           KIND_INT);
    push_op(CMD_DIV, 32'hFFFF_FFF9, KIND_INT,  '0,           KIND_INT);
    push_op(CMD_DIV, 32'hFFFF_FFF9, KIND_INT,  32'h0000_0002, KIND_INT);
    push_op(CMD_GR,  32'h7FFF_FFFF, KIND_INT,  32'h8000_0000, KIND_INT);
    push_op(CMD_GE,  32'h8000_0000, KIND_INT,  32'h8000_0000, KIND_INT);
    push_op(CMD_LS,  32'h8000_0000, KIND_INT,  32'h7FFF_FFFF, KIND_INT);
    push_op(CMD_LE,  '1,           KIND_INT,  32'h8000_0000, KIND_INT);
    push_op(CMD_RESERVED, 32'h0000_0001, KIND_INT, 32'h0000_0001, KIND_INT);

    for (int i = 0; i < RandomItems; i++) pending_ops = {pending_ops, make_random_op(i)};

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_ops.size() != 0 || op_ch.valid || expected_results.size() != 0)
      @(negedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #1_500_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

[tagged_integer_boolean_alu.f]
rtl/core/tiba_pkg.sv
rtl/core/tiba_if.sv
rtl/core/tagged_integer_boolean_alu.sv
bench/tb_tagged_integer_boolean_alu.sv
